FILE: src/srecord_s3_encoder_unit_macros.svh
// ----------------------------------------------------------------------------
// S-record encoder assertion macros
// Clocked, reset-gated property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef SRECORD_S3_ENCODER_UNIT_MACROS_SVH
`define SRECORD_S3_ENCODER_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SREC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SREC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/srec_pkg.sv
// ----------------------------------------------------------------------------
// S-record encoder package
// Shared constants, request codes, ASCII codes, control types and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srec_pkg;

   localparam int unsigned BYTES_PER_RECORD_DEF = 16;
   localparam int unsigned COUNT_EXTRA          = 5;

   // request codes
   localparam logic [1:0] REQ_BEGIN = 2'd0;
   localparam logic [1:0] REQ_DATA  = 2'd1;
   localparam logic [1:0] REQ_ENTRY = 2'd2;

   // ASCII
   localparam logic [7:0] CHAR_S  = 8'h53;
   localparam logic [7:0] CHAR_3  = 8'h33;
   localparam logic [7:0] CHAR_7  = 8'h37;
   localparam logic [7:0] CHAR_LF = 8'h0a;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_S,
      ST_KIND,
      ST_COUNT,
      ST_ADDR,
      ST_DATA,
      ST_SUM,
      ST_EOL
   } state_type;

   typedef enum logic [2:0] {
      SEL_S,
      SEL_KIND,
      SEL_COUNT,
      SEL_ADDR,
      SEL_DATA,
      SEL_SUM,
      SEL_EOL
   } char_sel_type;

   typedef struct packed {
      logic         load_item;    // apply accepted item to record state
      logic         setup_line;   // latch count, address, checksum of a line
      logic         line_s7;      // line being built is an S7 line
      logic         emit;         // load one character into the output stage
      logic         clear_record; // S3 line done, empty the record
      logic         lo_nib;       // low nibble of the current byte
      char_sel_type sel;
   } ctl_cmd_type;

   typedef struct packed {
      logic slot_free;      // output stage can take a character
      logic fill_zero;      // no bytes held
      logic fill_last_slot; // next data byte fills the record
   } dp_stat_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'b0000, nib};
      if (nib < 4'd10) begin
         return 8'h30 + wide;
      end else begin
         return 8'h57 + wide;
      end
   endfunction

endpackage

`default_nettype wire

FILE: src/srec_if.sv
// ----------------------------------------------------------------------------
// S-record encoder channels
// Valid/ready interfaces for the request items and the character items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface srec_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] address;
   logic [7:0]  byte_value;
   logic        last_of_group;

   modport source (output valid, req_type, address, byte_value, last_of_group,
                   input ready);
   modport sink   (input valid, req_type, address, byte_value, last_of_group,
                   output ready);
endinterface

interface srec_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       line_end;

   modport source (output valid, out_char, line_end, input ready);
   modport sink   (input valid, out_char, line_end, output ready);
endinterface

`default_nettype wire

FILE: src/srecord_s3_encoder_unit.sv
// ----------------------------------------------------------------------------
// S-record S3/S7 encoder
// Buffers data bytes into records and streams S3/S7 lines as ASCII characters.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                    | handshake
//  ---------+-----+--------------------------------------------+------------
//  req_chan | in  | req_type, address, byte_value, last_of_group | valid/ready
//  rsp_chan | out | out_char, line_end                         | valid/ready
//
//  A data byte that does not close a record leaves the encoder idle, ready for the next item.
//  A line takes a setup state, then its characters one at a time: an S3 line of
//  n bytes is 15 + 2n characters, an S7 line 15, and a flushing item holds
//  req_chan.ready low until its line (and, for an entry, the S7 line) is walked.
//  The single output register sets the pace: a stall on rsp_chan freezes the
//  line walk in place; nothing is dropped.
//  Reset (synchronous) empties the record and zeroes the running address.
//
`timescale 1ns / 1ps
`default_nettype none

module srecord_s3_encoder_unit import srec_pkg::*; #(
   parameter int unsigned BYTES_PER_RECORD = BYTES_PER_RECORD_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   srec_req_if.sink   req_chan,
   srec_rsp_if.source rsp_chan
);

   localparam int unsigned IDX_W = (BYTES_PER_RECORD > 1) ? $clog2(BYTES_PER_RECORD) : 1;
   localparam int unsigned POS_W = (BYTES_PER_RECORD > 4) ? $clog2(BYTES_PER_RECORD) : 2;

   ctl_cmd_type      cmd;
   dp_stat_type      stat;
   logic [POS_W-1:0] pos;
   logic [POS_W-1:0] rd_pos;
   logic [IDX_W-1:0] data_end_idx;
   logic             req_ready;
   logic             rsp_valid;
   logic [7:0]       rsp_out_char;
   logic             rsp_line_end;

   // controller: item decode and per-line field sequencing
   srec_ctrl #(
      .BYTES_PER_RECORD(BYTES_PER_RECORD)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_type     (req_chan.req_type),
      .req_last     (req_chan.last_of_group),
      .req_ready    (req_ready),
      .stat         (stat),
      .data_end_idx (data_end_idx),
      .cmd          (cmd),
      .pos          (pos),
      .rd_pos       (rd_pos)
   );

   // datapath: record buffer, checksum and the output character register;
   // rd_pos is the walk's next position, so the buffer read is registered
   srec_datapath #(
      .BYTES_PER_RECORD(BYTES_PER_RECORD)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .pos            (pos),
      .rd_pos         (rd_pos),
      .req_type       (req_chan.req_type),
      .req_address    (req_chan.address),
      .req_byte_value (req_chan.byte_value),
      .rsp_ready      (rsp_chan.ready),
      .stat           (stat),
      .data_end_idx   (data_end_idx),
      .rsp_valid      (rsp_valid),
      .rsp_out_char   (rsp_out_char),
      .rsp_line_end   (rsp_line_end)
   );

   assign req_chan.ready    = req_ready;
   assign rsp_chan.valid    = rsp_valid;
   assign rsp_chan.out_char = rsp_out_char;
   assign rsp_chan.line_end = rsp_line_end;

endmodule

`default_nettype wire

FILE: src/srec_datapath.sv
// ----------------------------------------------------------------------------
// S-record encoder datapath
// Record buffer, address/sum state, line fields and output character stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srec_datapath import srec_pkg::*; #(
   parameter int unsigned BYTES_PER_RECORD = BYTES_PER_RECORD_DEF,
   localparam int unsigned IDX_W  = (BYTES_PER_RECORD > 1) ? $clog2(BYTES_PER_RECORD) : 1,
   localparam int unsigned POS_W  = (BYTES_PER_RECORD > 4) ? $clog2(BYTES_PER_RECORD) : 2,
   localparam int unsigned FILL_W = $clog2(BYTES_PER_RECORD + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctl_cmd_type       cmd,
   input  wire logic [POS_W-1:0]  pos,
   input  wire logic [POS_W-1:0]  rd_pos,
   input  wire logic [1:0]        req_type,
   input  wire logic [31:0]       req_address,
   input  wire logic [7:0]        req_byte_value,
   input  wire logic              rsp_ready,
   output dp_stat_type            stat,
   output logic [IDX_W-1:0]       data_end_idx,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_out_char,
   output logic                   rsp_line_end
);

   logic [7:0]        record_bytes_ff [BYTES_PER_RECORD];
   logic [7:0]        data_byte_ff;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [31:0]       record_addr_ff, record_addr_in;
   logic [31:0]       next_addr_ff, next_addr_in;
   logic [7:0]        data_sum_ff, data_sum_in;
   logic [31:0]       entry_addr_ff, entry_addr_in;

   logic [7:0]        kind_ff, kind_in;
   logic [7:0]        count_ff, count_in;
   logic [31:0]       line_addr_ff, line_addr_in;
   logic [7:0]        chk_ff, chk_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic              rsp_end_ff, rsp_end_in;

   logic              is_data;
   logic [7:0]        dsum_sel;
   logic [7:0]        cur_byte;
   logic [7:0]        char_val;

   assign is_data = cmd.load_item && (req_type == REQ_DATA);

   // record state
   always_comb begin
      fill_in        = fill_ff;
      record_addr_in = record_addr_ff;
      next_addr_in   = next_addr_ff;
      data_sum_in    = data_sum_ff;
      entry_addr_in  = entry_addr_ff;
      if (cmd.load_item) begin
         unique case (req_type)
            REQ_BEGIN: begin
               next_addr_in = req_address;
            end
            REQ_DATA: begin
               if (fill_ff == '0) begin
                  record_addr_in = next_addr_ff;
               end
               fill_in      = fill_ff + FILL_W'(1);
               data_sum_in  = data_sum_ff + req_byte_value;
               next_addr_in = next_addr_ff + 32'd1;
            end
            REQ_ENTRY: begin
               entry_addr_in = req_address;
            end
            default: ;
         endcase
      end
      if (cmd.clear_record) begin
         fill_in     = '0;
         data_sum_in = '0;
      end
   end

   // line fields: count, address and checksum latched before the first char
   always_comb begin
      kind_in      = kind_ff;
      count_in     = count_ff;
      line_addr_in = line_addr_ff;
      chk_in       = chk_ff;
      dsum_sel     = cmd.line_s7 ? 8'd0 : data_sum_ff;
      if (cmd.setup_line) begin
         kind_in      = cmd.line_s7 ? CHAR_7 : CHAR_3;
         count_in     = cmd.line_s7 ? 8'(COUNT_EXTRA) : 8'(fill_ff) + 8'(COUNT_EXTRA);
         line_addr_in = cmd.line_s7 ? entry_addr_ff : record_addr_ff;
         chk_in       = ~(count_in + line_addr_in[31:24] + line_addr_in[23:16]
                          + line_addr_in[15:8] + line_addr_in[7:0] + dsum_sel);
      end
   end

   // character select
   always_comb begin
      cur_byte = chk_ff;
      case (cmd.sel)
         SEL_COUNT: cur_byte = count_ff;
         SEL_ADDR: begin
            case (pos[1:0])
               2'd0:    cur_byte = line_addr_ff[31:24];
               2'd1:    cur_byte = line_addr_ff[23:16];
               2'd2:    cur_byte = line_addr_ff[15:8];
               default: cur_byte = line_addr_ff[7:0];
            endcase
         end
         SEL_DATA: cur_byte = data_byte_ff;
         default:  cur_byte = chk_ff;
      endcase
      char_val = hex_char(cmd.lo_nib ? cur_byte[3:0] : cur_byte[7:4]);
      case (cmd.sel)
         SEL_S:    char_val = CHAR_S;
         SEL_KIND: char_val = kind_ff;
         SEL_EOL:  char_val = CHAR_LF;
         default:  ;
      endcase
   end

   // output stage
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_end_in   = rsp_end_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = char_val;
         rsp_end_in   = (cmd.sel == SEL_EOL);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff        <= '0;
         record_addr_ff <= '0;
         next_addr_ff   <= '0;
         data_sum_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         fill_ff        <= fill_in;
         record_addr_ff <= record_addr_in;
         next_addr_ff   <= next_addr_in;
         data_sum_ff    <= data_sum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_addr_ff <= entry_addr_in;
      kind_ff       <= kind_in;
      count_ff      <= count_in;
      line_addr_ff  <= line_addr_in;
      chk_ff        <= chk_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_end_ff    <= rsp_end_in;
   end

   // record buffer, written at the fill position; read at the walk's next
   // position so the byte is registered when its state comes up
   always_ff @(posedge clock) begin
      if (is_data) begin
         record_bytes_ff[fill_ff[IDX_W-1:0]] <= req_byte_value;
      end
      data_byte_ff <= record_bytes_ff[rd_pos[IDX_W-1:0]];
   end

   assign stat.slot_free      = !rsp_valid_ff || rsp_ready;
   assign stat.fill_zero      = (fill_ff == '0);
   assign stat.fill_last_slot = (fill_ff == FILL_W'(BYTES_PER_RECORD - 1));
   assign data_end_idx        = IDX_W'(fill_ff - FILL_W'(1));

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_line_end = rsp_end_ff;

endmodule

`default_nettype wire

FILE: src/srec_ctrl.sv
// ----------------------------------------------------------------------------
// S-record encoder controller
// Accepts items, decides flushes and walks the fields of each output line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srec_ctrl import srec_pkg::*; #(
   parameter int unsigned BYTES_PER_RECORD = BYTES_PER_RECORD_DEF,
   localparam int unsigned IDX_W = (BYTES_PER_RECORD > 1) ? $clog2(BYTES_PER_RECORD) : 1,
   localparam int unsigned POS_W = (BYTES_PER_RECORD > 4) ? $clog2(BYTES_PER_RECORD) : 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [1:0]       req_type,
   input  wire logic             req_last,
   output logic                  req_ready,
   input  wire dp_stat_type      stat,
   input  wire logic [IDX_W-1:0] data_end_idx,
   output ctl_cmd_type           cmd,
   output logic [POS_W-1:0]      pos,
   output logic [POS_W-1:0]      rd_pos
);

   state_type        state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             lo_ff, lo_in;
   logic             line_s7_ff, line_s7_in;
   logic             entry_pend_ff, entry_pend_in;

   // next state
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      lo_in         = lo_ff;
      line_s7_in    = line_s7_ff;
      entry_pend_in = entry_pend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_type)
                  REQ_DATA: begin
                     if (stat.fill_last_slot || req_last) begin
                        state_in      = ST_SETUP;
                        line_s7_in    = 1'b0;
                        entry_pend_in = 1'b0;
                     end
                  end
                  REQ_BEGIN: begin
                     if (!stat.fill_zero) begin
                        state_in      = ST_SETUP;
                        line_s7_in    = 1'b0;
                        entry_pend_in = 1'b0;
                     end
                  end
                  REQ_ENTRY: begin
                     // pending record goes out first, then the S7 line
                     state_in      = ST_SETUP;
                     line_s7_in    = stat.fill_zero;
                     entry_pend_in = !stat.fill_zero;
                  end
                  default: ;
               endcase
            end
         end
         ST_SETUP: begin
            state_in = ST_S;
            pos_in   = '0;
            lo_in    = 1'b0;
         end
         ST_S: begin
            if (stat.slot_free) begin
               state_in = ST_KIND;
            end
         end
         ST_KIND: begin
            if (stat.slot_free) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (stat.slot_free) begin
               lo_in = !lo_ff;
               if (lo_ff) begin
                  state_in = ST_ADDR;
                  pos_in   = '0;
               end
            end
         end
         ST_ADDR: begin
            if (stat.slot_free) begin
               lo_in = !lo_ff;
               if (lo_ff) begin
                  if (pos_ff == POS_W'(3)) begin
                     pos_in   = '0;
                     state_in = line_s7_ff ? ST_SUM : ST_DATA;
                  end else begin
                     pos_in = pos_ff + POS_W'(1);
                  end
               end
            end
         end
         ST_DATA: begin
            if (stat.slot_free) begin
               lo_in = !lo_ff;
               if (lo_ff) begin
                  if (pos_ff[IDX_W-1:0] == data_end_idx) begin
                     state_in = ST_SUM;
                  end else begin
                     pos_in = pos_ff + POS_W'(1);
                  end
               end
            end
         end
         ST_SUM: begin
            if (stat.slot_free) begin
               lo_in = !lo_ff;
               if (lo_ff) begin
                  state_in = ST_EOL;
               end
            end
         end
         ST_EOL: begin
            if (stat.slot_free) begin
               if (entry_pend_ff) begin
                  state_in      = ST_SETUP;
                  line_s7_in    = 1'b1;
                  entry_pend_in = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd              = '0;
      cmd.sel          = SEL_S;
      cmd.line_s7      = line_s7_ff;
      cmd.lo_nib       = lo_ff;
      req_ready        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_SETUP: begin
            cmd.setup_line = 1'b1;
         end
         ST_S: begin
            cmd.emit = stat.slot_free;
            cmd.sel  = SEL_S;
         end
         ST_KIND: begin
            cmd.emit = stat.slot_free;
            cmd.sel  = SEL_KIND;
         end
         ST_COUNT: begin
            cmd.emit = stat.slot_free;
            cmd.sel  = SEL_COUNT;
         end
         ST_ADDR: begin
            cmd.emit = stat.slot_free;
            cmd.sel  = SEL_ADDR;
         end
         ST_DATA: begin
            cmd.emit = stat.slot_free;
            cmd.sel  = SEL_DATA;
         end
         ST_SUM: begin
            cmd.emit = stat.slot_free;
            cmd.sel  = SEL_SUM;
         end
         ST_EOL: begin
            cmd.emit         = stat.slot_free;
            cmd.sel          = SEL_EOL;
            cmd.clear_record = stat.slot_free && !line_s7_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         lo_ff         <= 1'b0;
         line_s7_ff    <= 1'b0;
         entry_pend_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         lo_ff         <= lo_in;
         line_s7_ff    <= line_s7_in;
         entry_pend_ff <= entry_pend_in;
      end
   end

   assign pos    = pos_ff;
   assign rd_pos = pos_in;

endmodule

`default_nettype wire

FILE: src/srec_checker.sv
// ----------------------------------------------------------------------------
// S-record encoder checker
// Port-level properties of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "srecord_s3_encoder_unit_macros.svh"

module srec_checker import srec_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_type,
   input wire logic       req_last,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_char,
   input wire logic       rsp_end
);

   // stalled character holds
   `SREC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_char) && $stable(rsp_end), "stalled item changed")

   // newline and line_end go together
   `SREC_ASSERT_NOW(a_eol_match, clock, reset, rsp_valid, rsp_end == (rsp_char == CHAR_LF), "line_end does not match newline")

   // an entry item always produces a line
   `SREC_ASSERT_NEXT(a_entry_busy, clock, reset, req_valid && req_ready && (req_type == REQ_ENTRY), !req_ready, "entry item did not start a line")

   // a group-ending byte always flushes
   `SREC_ASSERT_NEXT(a_last_busy, clock, reset, req_valid && req_ready && (req_type == REQ_DATA) && req_last, !req_ready, "group end did not flush")

endmodule

bind srecord_s3_encoder_unit srec_checker u_srec_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_type  (req_chan.req_type),
   .req_last  (req_chan.last_of_group),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_char  (rsp_chan.out_char),
   .rsp_end   (rsp_chan.line_end)
);

`default_nettype wire

FILE: sim/tb_srecord_s3_encoder_unit.sv
// ----------------------------------------------------------------------------
// S-record S3/S7 encoder testbench
// Drives begin, data and entry items into the encoder and checks every
// character of the S3/S7 text it streams against an in-bench line predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_srecord_s3_encoder_unit;
   import srec_pkg::*;

   localparam int HALF_PERIOD = 5;
   localparam int REC_BYTES   = BYTES_PER_RECORD_DEF;

   // selector value the block must ignore
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // random items after the directed table
   localparam int RANDOM_ITEMS = 355;

   // idling phases, by count of accepted items
   localparam int PHASE_A = 135;   // sender 6 %, receiver 67 %
   localparam int PHASE_B = 270;   // sender 67 %, receiver 6 %, then no idling

   // long receiver hold-off: the single output register fills and the
   // encoder must back-pressure the request side
   localparam int HOLD_AT     = 320;
   localparam int HOLD_CYCLES = 400;

   // Cycles without any accepted item before the run is declared hung.
   // Worst legal quiet stretch is the hold-off above plus a few random
   // stalls, so this is several times that.
   localparam int STALL_LIMIT = 4000;

   // cycles to watch for stray characters once everything has arrived;
   // an entry item flushing a full record runs about 62 characters
   localparam int DRAIN_CYCLES = 80;

   localparam int REPORT_CAP = 40;

   // one stimulus row; typed rows carry their expected text verbatim
   typedef struct {
      logic [1:0]  kind;
      logic [31:0] addr;
      logic [7:0]  data;
      logic        last;
      bit          typed;
      string       line;
   } req_row_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eol;
   } srec_char_type;

   logic clock = 1'b0;
   logic reset;

   srec_req_if req_if ();
   srec_rsp_if rsp_if ();

   srecord_s3_encoder_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------------
   // Line predictor state: the record being filled and the running address
   // ------------------------------------------------------------------------
   logic [7:0]  held_bytes [REC_BYTES];
   int          held_count;
   logic [31:0] line_addr;     // address of first held byte
   logic [31:0] load_addr;     // where the next data byte lands
   logic [7:0]  held_sum;      // mod-256 sum of held bytes

   string       digit_set = "0123456789abcdef";

   srec_char_type line_chars [$];       // scratch output of one item
   srec_char_type expected_chars [$];   // characters still owed by the block

   req_row_type plan [$];

   // payload side info for the item currently offered
   bit          row_typed;
   string       row_line;

   int          items_taken;
   int          error_count;
   int          quiet_cycles;

   function automatic void put_char(input logic [7:0] c, input logic eol);
      line_chars.push_back('{ch: c, eol: eol});
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      put_char(digit_set[b[7:4]], 1'b0);
      put_char(digit_set[b[3:0]], 1'b0);
   endfunction

   // "S", kind, count, then the address high byte first
   function automatic void put_head(input logic [7:0] kind, input logic [7:0] count,
                                    input logic [31:0] a);
      put_char(CHAR_S, 1'b0);
      put_char(kind, 1'b0);
      put_byte(count);
      put_byte(a[31:24]);
      put_byte(a[23:16]);
      put_byte(a[15:8]);
      put_byte(a[7:0]);
   endfunction

   function automatic logic [7:0] addr_sum(input logic [31:0] a);
      return a[31:24] + a[23:16] + a[15:8] + a[7:0];
   endfunction

   // emit the held record as an S3 line, if any byte is held
   function automatic void flush_record();
      logic [7:0] count;
      logic [7:0] sum;
      if (held_count == 0) begin
         return;
      end
      count = 8'(held_count + COUNT_EXTRA);
      sum   = count + addr_sum(line_addr) + held_sum;
      put_head(CHAR_3, count, line_addr);
      for (int i = 0; i < held_count; i++) begin
         put_byte(held_bytes[i]);
      end
      put_byte(~sum);
      put_char(CHAR_LF, 1'b1);
      held_count = 0;
      held_sum   = 8'h00;
   endfunction

   // apply one accepted item; its characters land in line_chars
   function automatic void encode_item(input logic [1:0] kind, input logic [31:0] a,
                                       input logic [7:0] b, input logic last);
      logic [7:0] sum;
      case (kind)
         REQ_BEGIN: begin
            flush_record();
            load_addr = a;
         end
         REQ_DATA: begin
            if (held_count == 0) begin
               line_addr = load_addr;
            end
            held_bytes[held_count] = b;
            held_count++;
            held_sum  = held_sum + b;
            load_addr = load_addr + 32'd1;   // wraps at 32 bits
            if (held_count >= REC_BYTES || last) begin
               flush_record();
            end
         end
         REQ_ENTRY: begin
            flush_record();
            sum = 8'(COUNT_EXTRA) + addr_sum(a);
            put_head(CHAR_7, 8'(COUNT_EXTRA), a);
            put_byte(~sum);
            put_char(CHAR_LF, 1'b1);
         end
         default: begin
            // unused selector: ignored
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= REPORT_CAP) begin
         $display("%0t ns mismatch: %s", $time, what);
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitor: predict on each accepted request item, check each character.
   // Request side goes first; a character never comes out in the cycle
   // that accepts the item causing it, so this order is safe.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      srec_char_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            line_chars.delete();
            encode_item(req_if.req_type, req_if.address, req_if.byte_value,
                        req_if.last_of_group);
            if (row_typed) begin
               // directed row with hand-written text: trust the table
               for (int i = 0; i < row_line.len(); i++) begin
                  expected_chars.push_back('{ch: row_line[i],
                                             eol: (row_line[i] == CHAR_LF)});
               end
            end else begin
               foreach (line_chars[i]) begin
                  expected_chars.push_back(line_chars[i]);
               end
            end
            items_taken++;
         end

         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("char %02h with nothing expected",
                                         rsp_if.out_char));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_if.out_char !== want.ch) begin
                  report_mismatch($sformatf("out_char %02h, expected %02h",
                                            rsp_if.out_char, want.ch));
               end
               if (rsp_if.line_end !== want.eol) begin
                  report_mismatch($sformatf("line_end %0b, expected %0b on char %02h",
                                            rsp_if.line_end, want.eol, want.ch));
               end
            end
         end

         // watchdog: any handshake counts as progress
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stalls by phase, plus one long hold-off
   // ------------------------------------------------------------------------
   initial begin
      int  stall_pct;
      bit  hold_done;
      rsp_if.ready = 1'b0;
      hold_done    = 1'b0;
      forever begin
         @(negedge clock);
         stall_pct = (items_taken < PHASE_A) ? 67 : (items_taken < PHASE_B) ? 6 : 0;
         if (!hold_done && items_taken >= HOLD_AT) begin
            hold_done    = 1'b1;
            rsp_if.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_if.ready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------------
   task automatic add_row(input logic [1:0] kind, input logic [31:0] a,
                          input logic [7:0] b, input logic last,
                          input bit typed, input string line);
      plan.push_back('{kind: kind, addr: a, data: b, last: last,
                       typed: typed, line: line});
   endtask

   // addresses biased toward the 32-bit wrap and toward zero
   function automatic logic [31:0] pick_address();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'hffff_ffff - $urandom_range(40);
         2: return $urandom_range(255);
         default: return {16'($urandom_range(65535)), 16'hfff0};
      endcase
   endfunction

   task automatic plan_directed();
      // entry right after reset, lowest address
      add_row(REQ_ENTRY, 32'h0000_0000, 8'h00, 1'b0, 1'b1, "S70500000000fa\n");
      // data before any begin lands at address zero
      add_row(REQ_DATA, 32'hffff_ffff, 8'h00, 1'b1, 1'b1, "S3060000000000f9\n");
      // unused selector with every field at its top: no characters
      add_row(REQ_UNUSED, 32'hffff_ffff, 8'hff, 1'b1, 1'b1, "");
      // entry at the top address; unused fields set
      add_row(REQ_ENTRY, 32'hffff_ffff, 8'hff, 1'b1, 1'b1, "S705fffffffffe\n");
      // begin just below the wrap; nothing pending
      add_row(REQ_BEGIN, 32'hffff_fff8, 8'hff, 1'b1, 1'b1, "");
      // a full record that runs across the 32-bit wrap
      add_row(REQ_DATA, 32'h0, 8'hff, 1'b0, 1'b0, "");
      add_row(REQ_DATA, 32'h0, 8'h00, 1'b0, 1'b0, "");
      add_row(REQ_DATA, 32'h0, 8'h01, 1'b0, 1'b0, "");
      add_row(REQ_DATA, 32'h0, 8'h80, 1'b0, 1'b0, "");
      add_row(REQ_DATA, 32'h0, 8'h7f, 1'b0, 1'b0, "");
      add_row(REQ_DATA, 32'h0, 8'h5a, 1'b0, 1'b0, "");
      add_row(REQ_DATA, 32'h0, 8'ha5, 1'b0, 1'b0, "");
      add_row(REQ_DATA, 32'h0, 8'h10, 1'b0, 1'b0, "");
      add_row(REQ_DATA, 32'h0, 8'hfe, 1'b0, 1'b0, "");
      add_row(REQ_DATA, 32'h0, 8'h02, 1'b0, 1'b0, "");
      add_row(REQ_DATA, 32'h0, 8'h9c, 1'b0, 1'b0, "");
      add_row(REQ_DATA, 32'h0, 8'h3e, 1'b0, 1'b0, "");
      add_row(REQ_DATA, 32'h0, 8'hc7, 1'b0, 1'b0, "");
      add_row(REQ_DATA, 32'h0, 8'h41, 1'b0, 1'b0, "");
      add_row(REQ_DATA, 32'h0, 8'hee, 1'b0, 1'b0, "");
      add_row(REQ_DATA, 32'h0, 8'h0f, 1'b0, 1'b0, "");
      // partial record flushed by a begin, then by an entry
      add_row(REQ_DATA, 32'h0, 8'h3c, 1'b0, 1'b0, "");
      add_row(REQ_BEGIN, 32'h0000_1000, 8'h55, 1'b1, 1'b0, "");
      add_row(REQ_DATA, 32'h0, 8'h81, 1'b0, 1'b0, "");
      add_row(REQ_ENTRY, 32'h1234_5678, 8'haa, 1'b0, 1'b0, "");
   endtask

   // mostly well-formed groups with random content; some loose bytes,
   // bare begins, entries and ignored selectors mixed in
   task automatic plan_random(input int target);
      int taken;
      int pick;
      int len;
      int i;
      taken = 0;
      while (taken < target) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            add_row(REQ_BEGIN, pick_address(), 8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'b0, "");
            len = ($urandom_range(4) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 20);
            for (i = 1; i <= len; i++) begin
               add_row(REQ_DATA, $urandom, 8'($urandom_range(255)),
                       (i == len) ? ($urandom_range(99) < 85) : ($urandom_range(99) < 5),
                       1'b0, "");
            end
            taken += 1 + len;
         end else if (pick < 80) begin
            add_row(REQ_ENTRY, pick_address(), 8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'b0, "");
            taken++;
         end else if (pick < 90) begin
            // bytes continuing from wherever the last record stopped
            len = $urandom_range(1, 5);
            for (i = 0; i < len; i++) begin
               add_row(REQ_DATA, $urandom, 8'($urandom_range(255)),
                       ($urandom_range(99) < 30), 1'b0, "");
            end
            taken += len;
         end else if (pick < 95) begin
            add_row(REQ_UNUSED, $urandom, 8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'b0, "");
         end else begin
            add_row(REQ_BEGIN, pick_address(), 8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'b0, "");
            taken++;
         end
      end
   endtask

   // offer one row, with random gaps ahead of it, and wait for acceptance
   task automatic send_row(input req_row_type r);
      int gap_pct;
      gap_pct = (items_taken < PHASE_A) ? 6 : (items_taken < PHASE_B) ? 67 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid         = 1'b1;
      req_if.req_type      = r.kind;
      req_if.address       = r.addr;
      req_if.byte_value    = r.data;
      req_if.last_of_group = r.last;
      row_typed            = r.typed;
      row_line             = r.line;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.req_type      = REQ_BEGIN;
      req_if.address       = 32'h0;
      req_if.byte_value    = 8'h00;
      req_if.last_of_group = 1'b0;
      row_typed            = 1'b0;
      row_line             = "";
      held_count           = 0;
      line_addr            = 32'h0;
      load_addr            = 32'h0;
      held_sum             = 8'h00;
      items_taken          = 0;
      error_count          = 0;
      quiet_cycles         = 0;

      repeat (4) @(negedge clock);
      reset = 1'b0;

      plan_directed();
      plan_random(RANDOM_ITEMS);
      foreach (plan[i]) begin
         send_row(plan[i]);
      end
      req_if.valid = 1'b0;

      // everything owed must arrive; the watchdog bounds this wait
      while (expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
